// ===== design/ebfe_pkg.sv =====
// types, constants and the quadrature table for the encoder and button front end
package ebfe_pkg;

	localparam int unsigned DetentW     = 4;
	localparam int unsigned LongPressW  = 16;
	localparam int unsigned AutoOffW    = 24;
	localparam int unsigned AccumW      = 5;
	localparam int unsigned CfgDataW    = 24;
	localparam int unsigned CfgIndexW   = 2;

	localparam logic [DetentW-1:0]    DetentReset    = 4'd4;
	localparam logic [LongPressW-1:0] LongPressReset = 16'd800;
	localparam logic [AutoOffW-1:0]   AutoOffReset   = 24'd60000;
	localparam logic [1:0]            GrayReset      = 2'd3;
	localparam logic [AutoOffW-1:0]   IdleMax        = '1;

	typedef enum logic [CfgIndexW-1:0] {
		REG_DETENT     = 2'd0,
		REG_LONG_PRESS = 2'd1,
		REG_AUTO_OFF   = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic enc_a;
		logic enc_b;
		logic button_level;
	} in_item_t;

	typedef struct packed {
		logic step_up;
		logic step_down;
		logic click;
		logic back;
		logic display_on;
		logic activity;
	} out_item_t;

	// index is {previous gray state, current gray state}
	function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
		logic signed [1:0] d;
		case (idx)
			4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
			4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
			default: d = 2'sd0;
		endcase
		return d;
	endfunction

endpackage

// ===== design/ebfe_stream_if.sv =====
// valid/ready channel carrying one payload item per transfer
interface ebfe_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== design/encoder_button_input_front_end_core.sv =====
// encoder and button front end: quadrature decode, press timing and display timeout
//
//   channel   dir  payload              transfer
//   in_ch     in   enc_a enc_b button   valid & ready
//   out_ch    out  step/click/display   valid & ready
//   cfg       in   index, data          cfg_wr_en
//
// one sample is taken per cycle unless out_ch stalls; its result is registered
// the state registers and the result register are the only storage on the path
// a sample is taken while the result register is empty or being drained
// arst_n clears state to both pins high, button released, counters zero, display on
// configuration registers reset to detent 4, long press 800, auto off 60000
module encoder_button_input_front_end_core (
	input  logic                              clk,
	input  logic                              arst_n,
	ebfe_stream_if.sink                       in_ch,
	ebfe_stream_if.source                     out_ch,
	input  logic                              cfg_wr_en,
	input  logic [ebfe_pkg::CfgIndexW-1:0]    cfg_index,
	input  logic [ebfe_pkg::CfgDataW-1:0]     cfg_data
);

	logic [ebfe_pkg::DetentW-1:0]     detent_q;
	logic [ebfe_pkg::LongPressW-1:0]  long_press_q;
	logic [ebfe_pkg::AutoOffW-1:0]    auto_off_q;

	logic [1:0]                       gray_q;
	logic signed [ebfe_pkg::AccumW-1:0] accum_q;
	logic                             button_q;
	logic [ebfe_pkg::LongPressW-1:0]  held_q;
	logic [ebfe_pkg::AutoOffW-1:0]    idle_q;
	logic                             display_q;

	ebfe_pkg::out_item_t              res_q;
	logic                             res_valid_q;

	logic                             accept;
	ebfe_pkg::in_item_t               smp;
	logic [1:0]                       gray_cur;
	logic                             enc_change;
	logic signed [1:0]                quad_d;
	logic signed [ebfe_pkg::AccumW:0] det_s;
	logic signed [ebfe_pkg::AccumW:0] accum_sum;
	logic signed [ebfe_pkg::AccumW:0] accum_adj;
	logic                             up;
	logic                             down;
	logic [ebfe_pkg::LongPressW-1:0]  held_inc;
	logic                             click;
	logic                             back;
	logic                             act;
	logic [ebfe_pkg::LongPressW-1:0]  held_d;
	logic [ebfe_pkg::AutoOffW-1:0]    idle_d;
	logic                             display_d;
	ebfe_pkg::cfg_reg_t               cfg_sel;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = !res_valid_q || out_ch.ready;
	assign out_ch.valid = res_valid_q;
	assign out_ch.data  = res_q;
	assign smp          = in_ch.data;
	assign cfg_sel      = ebfe_pkg::cfg_reg_t'(cfg_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			detent_q     <= ebfe_pkg::DetentReset;
			long_press_q <= ebfe_pkg::LongPressReset;
			auto_off_q   <= ebfe_pkg::AutoOffReset;
		end else if (cfg_wr_en) begin
			case (cfg_sel)
				ebfe_pkg::REG_DETENT:     detent_q     <= cfg_data[ebfe_pkg::DetentW-1:0];
				ebfe_pkg::REG_LONG_PRESS: long_press_q <= cfg_data[ebfe_pkg::LongPressW-1:0];
				ebfe_pkg::REG_AUTO_OFF:   auto_off_q   <= cfg_data[ebfe_pkg::AutoOffW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		gray_cur   = {smp.enc_a, smp.enc_b};
		enc_change = (gray_cur != gray_q);
		quad_d     = ebfe_pkg::quad_delta({gray_q, gray_cur});
		// zero detent behaves as one
		det_s      = (detent_q == '0) ? 6'sd1 : $signed({2'b00, detent_q});
		accum_sum  = $signed({accum_q[ebfe_pkg::AccumW-1], accum_q})
			+ $signed({{(ebfe_pkg::AccumW-1){quad_d[1]}}, quad_d});
		up         = enc_change && (accum_sum >= det_s);
		down       = enc_change && !up && (accum_sum <= -det_s);
		accum_adj  = up ? accum_sum - det_s : (down ? accum_sum + det_s : accum_sum);

		held_inc   = (held_q >= long_press_q) ? long_press_q : held_q + 1'b1;
		click      = 1'b0;
		back       = 1'b0;
		held_d     = held_q;
		if (smp.button_level != button_q) begin
			if (!smp.button_level) begin
				held_d = '0;
			end else if (held_inc >= long_press_q) begin
				back = 1'b1;
			end else begin
				click = 1'b1;
			end
		end else if (!smp.button_level) begin
			held_d = held_inc;
		end

		act       = enc_change || click || back;
		idle_d    = '0;
		display_d = 1'b1;
		if (!act) begin
			idle_d    = (idle_q == ebfe_pkg::IdleMax) ? idle_q : idle_q + 1'b1;
			display_d = display_q && !(idle_d > auto_off_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gray_q    <= ebfe_pkg::GrayReset;
			accum_q   <= '0;
			button_q  <= 1'b1;
			held_q    <= '0;
			idle_q    <= '0;
			display_q <= 1'b1;
		end else if (accept) begin
			gray_q    <= gray_cur;
			if (enc_change) begin
				accum_q <= accum_adj[ebfe_pkg::AccumW-1:0];
			end
			button_q  <= smp.button_level;
			held_q    <= held_d;
			idle_q    <= idle_d;
			display_q <= display_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.step_up    <= up;
			res_q.step_down  <= down;
			res_q.click      <= click;
			res_q.back       <= back;
			res_q.display_on <= display_d;
			res_q.activity   <= act;
		end
	end

	a_step_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.step_up && res_q.step_down))
		else $error("step up and step down in one result");

	a_release_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> !(res_q.click && res_q.back))
		else $error("click and back in one result");

	a_event_activity: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.step_up || res_q.step_down || res_q.click || res_q.back)
		|-> res_q.activity && res_q.display_on)
		else $error("event without activity or with display off");

	a_display_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept) |-> res_q.display_on == display_q)
		else $error("result display flag differs from display state");

endmodule

// ===== verif/encoder_button_input_front_end_core_tb.sv =====
// testbench for the encoder and button front end: scripted and random pin samples
module encoder_button_input_front_end_core_tb;

	// expected panel events, one per accepted pin sample
	class panel_event_scoreboard;
		logic [ebfe_pkg::DetentW-1:0]    detent;
		logic [ebfe_pkg::LongPressW-1:0] long_press;
		logic [ebfe_pkg::AutoOffW-1:0]   auto_off;

		logic [1:0]                      gray_prev;
		int                              accum;
		logic                            button_prev;
		logic [ebfe_pkg::LongPressW-1:0] held;
		logic [ebfe_pkg::AutoOffW-1:0]   idle;
		logic                            display;

		ebfe_pkg::out_item_t expected_events[$];
		int                  errors;
		string               field_name[6] = '{"activity", "display_on", "back", "click",
			"step_down", "step_up"};

		function new();
			detent      = ebfe_pkg::DetentReset;
			long_press  = ebfe_pkg::LongPressReset;
			auto_off    = ebfe_pkg::AutoOffReset;
			gray_prev   = ebfe_pkg::GrayReset;
			accum       = 0;
			button_prev = 1'b1;
			held        = '0;
			idle        = '0;
			display     = 1'b1;
			errors      = 0;
		endfunction

		function void write_reg(ebfe_pkg::cfg_reg_t r, logic [ebfe_pkg::CfgDataW-1:0] v);
			case (r)
				ebfe_pkg::REG_DETENT:     detent = v[ebfe_pkg::DetentW-1:0];
				ebfe_pkg::REG_LONG_PRESS: long_press = v[ebfe_pkg::LongPressW-1:0];
				ebfe_pkg::REG_AUTO_OFF:   auto_off = v[ebfe_pkg::AutoOffW-1:0];
				default: ;
			endcase
		endfunction

		// place of a gray code along the forward rotation 3, 1, 0, 2
		function int ring_pos(logic [1:0] g);
			case (g)
				2'd3: return 0;
				2'd1: return 1;
				2'd0: return 2;
				default: return 3;
			endcase
		endfunction

		function int transition_delta(logic [1:0] p, logic [1:0] c);
			int d;
			d = (ring_pos(c) - ring_pos(p) + 4) % 4;
			if (d == 1) return 1;
			if (d == 3) return -1;
			return 0;
		endfunction

		function logic [ebfe_pkg::LongPressW-1:0] bump_hold(
				logic [ebfe_pkg::LongPressW-1:0] v);
			if (v >= long_press) return long_press;
			return v + 1'b1;
		endfunction

		function void note_sample(ebfe_pkg::in_item_t s);
			logic [1:0]                      cur;
			int                              det;
			logic [ebfe_pkg::LongPressW-1:0] held_now;
			ebfe_pkg::out_item_t             e;
			cur = {s.enc_a, s.enc_b};
			det = (detent == '0) ? 1 : int'(detent);
			e = '0;
			if (cur != gray_prev) begin
				accum += transition_delta(gray_prev, cur);
				gray_prev = cur;
				if (accum >= det) begin
					e.step_up = 1'b1;
					accum -= det;
				end else if (accum <= -det) begin
					e.step_down = 1'b1;
					accum += det;
				end
				e.activity = 1'b1;
			end
			if (s.button_level != button_prev) begin
				if (!s.button_level) begin
					held = '0;
				end else begin
					// the release tick itself counts toward the hold
					held_now = bump_hold(held);
					if (held_now >= long_press) e.back = 1'b1;
					else e.click = 1'b1;
					e.activity = 1'b1;
				end
				button_prev = s.button_level;
			end else if (!s.button_level) begin
				held = bump_hold(held);
			end
			if (e.activity) begin
				idle    = '0;
				display = 1'b1;
			end else begin
				if (idle != ebfe_pkg::IdleMax) idle = idle + 1'b1;
				if (display && idle > auto_off) display = 1'b0;
			end
			e.display_on = display;
			expected_events.push_back(e);
		endfunction

		function void check_event(ebfe_pkg::out_item_t got);
			ebfe_pkg::out_item_t want;
			if (expected_events.size() == 0) begin
				errors++;
				if (errors < 50) $display("%0t: unexpected result %b", $time, got);
				return;
			end
			want = expected_events.pop_front();
			for (int i = 0; i < 6; i++) begin
				if (got[i] !== want[i]) begin
					errors++;
					if (errors < 50)
						$display("%0t: %s expected %0b actual %0b", $time, field_name[i],
							want[i], got[i]);
				end
			end
		endfunction

		function int pending();
			return expected_events.size();
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           cfg_wr_en;
	logic [ebfe_pkg::CfgIndexW-1:0] cfg_index;
	logic [ebfe_pkg::CfgDataW-1:0]  cfg_data;

	ebfe_stream_if #(.payload_t(ebfe_pkg::in_item_t))  sample_ch ();
	ebfe_stream_if #(.payload_t(ebfe_pkg::out_item_t)) event_ch ();

	encoder_button_input_front_end_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (sample_ch),
		.out_ch    (event_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	panel_event_scoreboard board;

	logic [1:0] gen_gray;
	logic       gen_btn;
	bit         gen_dir;
	int         hold_left;
	int         idle_left;
	bit         quiet_in;
	bit         quiet_out;

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n === 1'b1 && sample_ch.valid && sample_ch.ready)
			board.note_sample(sample_ch.data);
		if (arst_n === 1'b1 && event_ch.valid && event_ch.ready)
			board.check_event(event_ch.data);
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80) return $urandom_range(1, 3);
		if (r < 95) return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// hold lengths cluster around the long press threshold when it is reachable
	function automatic int pick_hold();
		int v;
		if (board.long_press <= 60 && $urandom_range(0, 1) == 1) begin
			v = int'(board.long_press) - 2 + int'($urandom_range(0, 3));
			return (v < 0) ? 0 : v;
		end
		return $urandom_range(0, 30);
	endfunction

	function automatic logic [1:0] turn(logic [1:0] g, bit fwd);
		case (g)
			2'd3: return fwd ? 2'd1 : 2'd2;
			2'd1: return fwd ? 2'd0 : 2'd3;
			2'd0: return fwd ? 2'd2 : 2'd1;
			default: return fwd ? 2'd3 : 2'd0;
		endcase
	endfunction

	task automatic send_sample(input ebfe_pkg::in_item_t s);
		@(negedge clk);
		if (!quiet_in && $urandom_range(0, 3) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat (pick_gap()) @(negedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= s;
		gen_gray = {s.enc_a, s.enc_b};
		gen_btn  = s.button_level;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	task automatic settle();
		@(negedge clk);
		sample_ch.valid <= 1'b0;
		while (board.pending() != 0) @(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic configure(input logic [ebfe_pkg::DetentW-1:0] det,
			input logic [ebfe_pkg::LongPressW-1:0] lp,
			input logic [ebfe_pkg::AutoOffW-1:0] ao);
		logic [31:0]                   raw;
		logic [ebfe_pkg::CfgDataW-1:0] junk;
		raw  = $urandom();
		junk = raw[ebfe_pkg::CfgDataW-1:0];
		// unused upper data bits carry noise
		cfg_wr_en <= 1'b1;
		cfg_index <= ebfe_pkg::REG_DETENT;
		cfg_data  <= {junk[ebfe_pkg::CfgDataW-1:ebfe_pkg::DetentW], det};
		board.write_reg(ebfe_pkg::REG_DETENT,
			{junk[ebfe_pkg::CfgDataW-1:ebfe_pkg::DetentW], det});
		@(negedge clk);
		cfg_index <= ebfe_pkg::REG_LONG_PRESS;
		cfg_data  <= {junk[ebfe_pkg::CfgDataW-1:ebfe_pkg::LongPressW], lp};
		board.write_reg(ebfe_pkg::REG_LONG_PRESS,
			{junk[ebfe_pkg::CfgDataW-1:ebfe_pkg::LongPressW], lp});
		@(negedge clk);
		cfg_index <= ebfe_pkg::REG_AUTO_OFF;
		cfg_data  <= ao;
		board.write_reg(ebfe_pkg::REG_AUTO_OFF, ao);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_random(input int n);
		logic [1:0] ng;
		logic       nb;
		int         r;
		for (int k = 0; k < n; k++) begin
			if (idle_left > 0) begin
				idle_left--;
				ng = gen_gray;
			end else begin
				r = $urandom_range(0, 99);
				if ($urandom_range(0, 15) == 0) gen_dir = !gen_dir;
				if (r < 50) ng = turn(gen_gray, gen_dir);
				else if (r < 55) ng = gen_gray ^ 2'b11;
				else if (r < 60) ng = 2'($urandom_range(0, 3));
				else ng = gen_gray;
				if ($urandom_range(0, 99) < 4) idle_left = $urandom_range(2, 40);
			end
			if (!gen_btn) begin
				if (hold_left == 0) begin
					nb = 1'b1;
				end else begin
					hold_left--;
					nb = 1'b0;
				end
			end else if ($urandom_range(0, 99) < 8) begin
				nb = 1'b0;
				hold_left = pick_hold();
			end else begin
				nb = 1'b1;
			end
			send_sample({ng, nb});
		end
	endtask

	task automatic phase(input logic [ebfe_pkg::DetentW-1:0] det,
			input logic [ebfe_pkg::LongPressW-1:0] lp,
			input logic [ebfe_pkg::AutoOffW-1:0] ao, input int n, input bit qin,
			input bit qout);
		settle();
		configure(det, lp, ao);
		quiet_in  = qin;
		quiet_out = qout;
		run_random(n);
	endtask

	initial begin
		event_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!quiet_out && $urandom_range(0, 3) == 0) begin
				event_ch.ready <= 1'b0;
				repeat (pick_gap() - 1) @(negedge clk);
			end else begin
				event_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		#4000000;
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		// {enc_a, enc_b, button_level}
		logic [2:0] script[21] = '{
			3'b111,
			3'b011, 3'b001, 3'b101, 3'b111,
			3'b101, 3'b001, 3'b011, 3'b111,
			3'b001, 3'b111,
			3'b011, 3'b111,
			3'b110, 3'b110, 3'b110, 3'b111,
			3'b010, 3'b001, 3'b101, 3'b111
		};
		board = new();
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.data  = '0;
		cfg_wr_en = 1'b0;
		cfg_index = ebfe_pkg::REG_DETENT;
		cfg_data  = '0;
		gen_gray  = ebfe_pkg::GrayReset;
		gen_btn   = 1'b1;
		gen_dir   = 1'b1;
		hold_left = 0;
		idle_left = 0;
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// full detents both ways, double-bit jumps, a short press, press and release while turning
		foreach (script[i]) send_sample(script[i]);
		run_random(40);

		phase(4'd1, 16'd1, 24'd0, 60, 1'b0, 1'b0);
		phase(4'd8, 16'd65535, 24'd16777215, 60, 1'b1, 1'b1);
		phase(4'd0, 16'd0, 24'd1, 60, 1'b0, 1'b0);
		phase(4'd15, 16'd12, 24'd20, 70, 1'b0, 1'b0);
		phase(4'd9, 16'd3, 24'd5, 60, 1'b1, 1'b0);
		phase(4'd2, 16'd40, 24'd8, 60, 1'b0, 1'b1);
		phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
			24'($urandom_range(0, 50)), 50, 1'b0, 1'b0);
		phase(4'($urandom_range(0, 15)), 16'($urandom_range(0, 40)),
			24'($urandom_range(0, 50)), 50, 1'b0, 1'b0);
		settle();

		if (board.errors == 0 && board.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
